[hw/rtl/nsc_pkg.sv]
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, character constants and small lookup functions shared by the NMEA
// sentence checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  localparam int unsigned TALKER_LEN = 6;

  localparam logic [4:0] FIELD_SELECT_RESET = 5'd2;
  localparam logic [4:0] COMMA_COUNT_MAX    = 5'd31;
  localparam logic [1:0] HEX_DIGITS         = 2'd2;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_VTG   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic       field_char_valid;
    logic [7:0] field_char;
    logic       sentence_done;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [1:0] sentence_kind;
  } out_item_t;

  function automatic logic [7:0] gga_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] vtg_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h4E;
      3'd3:    ch = 8'h56;
      3'd4:    ch = 8'h54;
      3'd5:    ch = 8'h47;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/nsc_if.sv]
// ----------------------------------------------------------------------------
// nsc_if
// Valid/ready channel interfaces for sentence bytes and checker results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsc_in_if;
  logic               valid;
  logic               ready;
  nsc_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nsc_out_if;
  logic               valid;
  logic               ready;
  nsc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/nsc_in_reg.sv]
// ----------------------------------------------------------------------------
// nsc_in_reg
// Input register stage: holds one sentence byte until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  nsc_in_if.sink             in_ch,
  output nsc_pkg::in_item_t  item,
  output logic               item_valid,
  input  wire logic          item_take
);

  logic              valid_r;
  logic              valid_nxt;
  nsc_pkg::in_item_t data_r;

  assign in_ch.ready = !valid_r || item_take;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= in_ch.payload;
    end
  end

  assign item       = data_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

[hw/rtl/nsc_core.sv]
// ----------------------------------------------------------------------------
// nsc_core
// Sentence state, checksum and field logic with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_core #(
  parameter int MAX_SENTENCE_BYTES = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [4:0]       cfg_wr_data,
  input  wire nsc_pkg::in_item_t item,
  input  wire logic             item_valid,
  output logic                  item_take,
  nsc_out_if.source             out_ch
);

  localparam logic [7:0] MaxBytes = 8'(MAX_SENTENCE_BYTES);

  logic [4:0] field_select_r;
  logic [7:0] xor_r, xor_nxt;
  logic       star_r, star_nxt;
  logic [1:0] hex_cnt_r, hex_cnt_nxt;
  logic [7:0] hex_val_r, hex_val_nxt;
  logic       hex_err_r, hex_err_nxt;
  logic [4:0] comma_r, comma_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [1:0] talker_r, talker_nxt;

  logic               out_valid_r;
  nsc_pkg::out_item_t out_data_r;
  nsc_pkg::out_item_t result;
  nsc_pkg::kind_t     kind;

  logic [7:0] c;
  logic       take;
  logic       proc;
  logic       fvalid;
  logic [4:0] hex_d;

  assign item_take = item_valid && (!out_valid_r || out_ch.ready);
  assign c         = item.char_in;

  always_comb begin
    xor_nxt     = xor_r;
    star_nxt    = star_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_val_nxt = hex_val_r;
    hex_err_nxt = hex_err_r;
    comma_nxt   = comma_r;
    pos_nxt     = pos_r;
    talker_nxt  = talker_r;
    fvalid      = 1'b0;
    hex_d       = nsc_pkg::hex_of(c);
    take        = (c != 8'd0) && !(star_r && hex_cnt_r >= nsc_pkg::HEX_DIGITS);
    proc        = take && (pos_r < MaxBytes);

    if (take && !proc) begin
      hex_err_nxt = 1'b1;
    end
    if (proc) begin
      if (pos_r < 8'(nsc_pkg::TALKER_LEN)) begin
        if (c != nsc_pkg::gga_char(pos_r[2:0])) begin
          talker_nxt[0] = 1'b0;
        end
        if (c != nsc_pkg::vtg_char(pos_r[2:0])) begin
          talker_nxt[1] = 1'b0;
        end
      end
      pos_nxt = pos_r + 8'd1;
      if (star_r) begin
        if (!hex_d[4]) begin
          hex_err_nxt = 1'b1;
        end else begin
          hex_val_nxt = {hex_val_r[3:0], hex_d[3:0]};
        end
        hex_cnt_nxt = hex_cnt_r + 2'd1;
      end else if (c == nsc_pkg::CHAR_STAR) begin
        star_nxt = 1'b1;
      end else begin
        if (c != nsc_pkg::CHAR_DOLLAR) begin
          xor_nxt = xor_r ^ c;
        end
        if (c == nsc_pkg::CHAR_COMMA) begin
          if (comma_r < nsc_pkg::COMMA_COUNT_MAX) begin
            comma_nxt = comma_r + 5'd1;
          end
        end else if (field_select_r != 5'd0 && comma_r == field_select_r - 5'd1) begin
          fvalid = 1'b1;
        end
      end
    end
  end

  always_comb begin
    kind = nsc_pkg::KIND_OTHER;
    if (pos_nxt >= 8'(nsc_pkg::TALKER_LEN)) begin
      if (talker_nxt[0]) begin
        kind = nsc_pkg::KIND_GGA;
      end else if (talker_nxt[1]) begin
        kind = nsc_pkg::KIND_VTG;
      end
    end
  end

  always_comb begin
    result.field_char_valid = fvalid;
    result.field_char       = fvalid ? c : 8'd0;
    result.sentence_done    = item.end_of_line;
    result.checksum_ok      = item.end_of_line && star_nxt &&
                              hex_cnt_nxt == nsc_pkg::HEX_DIGITS &&
                              !hex_err_nxt && xor_nxt == hex_val_nxt;
    result.computed_sum     = xor_nxt;
    result.received_sum     = hex_val_nxt;
    result.sentence_kind    = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_select_r <= nsc_pkg::FIELD_SELECT_RESET;
    end else if (cfg_wr_en) begin
      field_select_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (item_take && item.end_of_line)) begin
      xor_r     <= 8'd0;
      star_r    <= 1'b0;
      hex_cnt_r <= 2'd0;
      hex_val_r <= 8'd0;
      hex_err_r <= 1'b0;
      comma_r   <= 5'd0;
      pos_r     <= 8'd0;
      talker_r  <= 2'b11;
    end else if (item_take) begin
      xor_r     <= xor_nxt;
      star_r    <= star_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_val_r <= hex_val_nxt;
      hex_err_r <= hex_err_nxt;
      comma_r   <= comma_nxt;
      pos_r     <= pos_nxt;
      talker_r  <= talker_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  a_ok_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.checksum_ok |-> out_data_r.sentence_done)
    else $error("checksum_ok reported on a byte that does not end a sentence");

  a_clear_after_end : assert property (@(posedge clk) disable iff (!rst_n)
    $past(item_take && item.end_of_line) |-> pos_r == 8'd0 && !star_r && talker_r == 2'b11)
    else $error("sentence state not cleared after the last byte");

  a_digits_need_star : assert property (@(posedge clk) disable iff (!rst_n)
    !star_r |-> hex_cnt_r == 2'd0)
    else $error("checksum digits counted before the star");

  a_digit_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    hex_cnt_r != 2'd3)
    else $error("checksum digit count beyond two");

  a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MaxBytes)
    else $error("byte position ran past the sentence limit");

endmodule

`default_nettype wire

[hw/rtl/nmea_sentence_checker.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// NMEA 0183 sentence checksum verifier and field extractor.
//
// Sentence bytes arrive on in_ch (char_in plus an end_of_line mark on the
// last byte). Every transfer on in_ch produces exactly one transfer on
// out_ch, in order. A result carries the selected field character, if any,
// the running checksum, the received checksum, the talker kind and, on the
// last byte, the checksum verdict.
// The byte is captured in an input register and processed into the result
// register, from which the result is offered on out_ch. One byte per cycle
// is sustained while out_ch is not stalled; the running sentence state is
// the only feedback loop.
// When out_ch is stalled, the result register and the input register each
// hold one item before in_ch.ready drops.
// The cfg_ port writes field_select; the user must use it only while the
// block is idle, which the block itself does not enforce. Synchronous reset
// clears both stages, sets field_select to two and starts a fresh sentence.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker #(
  parameter int MAX_SENTENCE_BYTES = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  nsc_in_if.sink          in_ch,
  nsc_out_if.source       out_ch
);

  nsc_pkg::in_item_t item;
  logic              item_valid;
  logic              item_take;

  nsc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  nsc_core #(
    .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[verif/nmea_sentence_checker_tb.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_checker_tb
// Drives NMEA sentences through the checker one byte per transfer and checks
// every result against a byte-level model of the checksum and field parser.
// A short scripted run covers the talker kinds, bad digits, short
// checksums, a missing star and a lone zero byte. Random sentences follow
// under several field selections, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES = 128;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES = 6;
  localparam logic [47:0] GGA_TAG = "$GNGGA";
  localparam logic [47:0] VTG_TAG = "$GNVTG";

  typedef struct packed {
    logic [7:0] acc;
    logic       star;
    logic [1:0] ndig;
    logic [7:0] hexv;
    logic       herr;
    logic [4:0] commas;
    logic [7:0] pos;
    logic [1:0] talker;
  } scan_state_t;

  localparam scan_state_t FRESH_SENTENCE =
    '{8'h00, 1'b0, 2'd0, 8'h00, 1'b0, 5'd0, 8'd0, 2'b11};

  typedef struct packed {
    logic [7:0]         ch;
    logic               eol;
    logic               typed;
    nsc_pkg::out_item_t res;
  } script_row_t;

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT_BYTES [SCRIPT_LEN] = '{
    '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00, nsc_pkg::KIND_OTHER}},
    '{"$", 1'b0, 1'b0, '0},
    '{"G", 1'b0, 1'b0, '0},
    '{"N", 1'b0, 1'b0, '0},
    '{"G", 1'b0, 1'b0, '0},
    '{"G", 1'b0, 1'b0, '0},
    '{"A", 1'b0, 1'b0, '0},
    '{"*", 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, '0},
    '{"8", 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 8'h48, 8'h48, nsc_pkg::KIND_GGA}},
    '{"$", 1'b0, 1'b0, '0},
    '{"G", 1'b0, 1'b0, '0},
    '{"N", 1'b0, 1'b0, '0},
    '{"V", 1'b0, 1'b0, '0},
    '{"T", 1'b0, 1'b0, '0},
    '{"G", 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{"*", 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, '0},
    '{"g", 1'b0, 1'b0, '0},
    '{"Z", 1'b1, 1'b0, '0},
    '{"B", 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, 8'h42, 8'h00, nsc_pkg::KIND_OTHER}},
    '{"*", 1'b0, 1'b0, '0},
    '{"5", 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [4:0] cfg_wr_data;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  nmea_sentence_checker #(
    .MAX_SENTENCE_BYTES(MAX_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scan_state_t sentence = FRESH_SENTENCE;
  logic [4:0] field_sel = nsc_pkg::FIELD_SELECT_RESET;
  nsc_pkg::out_item_t byte_results_due [$];
  logic [7:0] sentence_bytes [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  function automatic nsc_pkg::out_item_t scan_byte(nsc_pkg::in_item_t it);
    nsc_pkg::out_item_t r;
    logic [7:0] c;
    logic [3:0] nib;
    bit is_hex;
    bit in_field;
    bit sum_done;
    int idx;
    c = it.char_in;
    r = '0;
    in_field = 1'b0;
    sum_done = sentence.star && sentence.ndig >= 2'd2;
    if (c != 8'h00 && !sum_done) begin
      if (sentence.pos >= MAX_BYTES) begin
        sentence.herr = 1'b1;
      end else begin
        if (sentence.pos < 6) begin
          idx = 47 - 8 * int'(sentence.pos);
          if (c != GGA_TAG[idx -: 8]) sentence.talker[0] = 1'b0;
          if (c != VTG_TAG[idx -: 8]) sentence.talker[1] = 1'b0;
        end
        sentence.pos = sentence.pos + 8'd1;
        if (sentence.star) begin
          is_hex = 1'b1;
          nib = 4'd0;
          if (c >= "0" && c <= "9") begin
            nib = c[3:0];
          end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            nib = c[3:0] + 4'd9;
          end else begin
            is_hex = 1'b0;
          end
          if (is_hex) begin
            sentence.hexv = {sentence.hexv[3:0], nib};
          end else begin
            sentence.herr = 1'b1;
          end
          sentence.ndig = sentence.ndig + 2'd1;
        end else if (c == nsc_pkg::CHAR_STAR) begin
          sentence.star = 1'b1;
        end else begin
          if (c != nsc_pkg::CHAR_DOLLAR) sentence.acc = sentence.acc ^ c;
          if (c == nsc_pkg::CHAR_COMMA) begin
            if (sentence.commas != nsc_pkg::COMMA_COUNT_MAX)
              sentence.commas = sentence.commas + 5'd1;
          end else if (field_sel != 5'd0 && sentence.commas == field_sel - 5'd1) begin
            in_field = 1'b1;
          end
        end
      end
    end
    r.field_char_valid = in_field;
    r.field_char = in_field ? c : 8'h00;
    r.sentence_done = it.end_of_line;
    r.checksum_ok = it.end_of_line && sentence.star && sentence.ndig == nsc_pkg::HEX_DIGITS &&
                    !sentence.herr && sentence.acc == sentence.hexv;
    r.computed_sum = sentence.acc;
    r.received_sum = sentence.hexv;
    if (sentence.pos < 6) r.sentence_kind = nsc_pkg::KIND_OTHER;
    else if (sentence.talker[0]) r.sentence_kind = nsc_pkg::KIND_GGA;
    else if (sentence.talker[1]) r.sentence_kind = nsc_pkg::KIND_VTG;
    else r.sentence_kind = nsc_pkg::KIND_OTHER;
    if (it.end_of_line) sentence = FRESH_SENTENCE;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in result %0d, %s: got %0h, expected %0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    nsc_pkg::out_item_t got;
    nsc_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (byte_results_due.size() == 0) begin
        report_mismatch("transfer with nothing pending", int'(got), 0);
      end else begin
        want = byte_results_due.pop_front();
        if (got.field_char_valid !== want.field_char_valid)
          report_mismatch("field_char_valid", int'(got.field_char_valid),
                          int'(want.field_char_valid));
        if (got.field_char !== want.field_char)
          report_mismatch("field_char", int'(got.field_char), int'(want.field_char));
        if (got.sentence_done !== want.sentence_done)
          report_mismatch("sentence_done", int'(got.sentence_done),
                          int'(want.sentence_done));
        if (got.checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", int'(got.checksum_ok), int'(want.checksum_ok));
        if (got.computed_sum !== want.computed_sum)
          report_mismatch("computed_sum", int'(got.computed_sum), int'(want.computed_sum));
        if (got.received_sum !== want.received_sum)
          report_mismatch("received_sum", int'(got.received_sum), int'(want.received_sum));
        if (got.sentence_kind !== want.sentence_kind)
          report_mismatch("sentence_kind", int'(got.sentence_kind),
                          int'(want.sentence_kind));
      end
      results_seen++;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_item(logic [7:0] ch, logic eol, bit use_typed,
                           nsc_pkg::out_item_t typed_res);
    nsc_pkg::in_item_t it;
    nsc_pkg::out_item_t predicted;
    it.char_in = ch;
    it.end_of_line = eol;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = scan_byte(it);
    byte_results_due.push_back(use_typed ? typed_res : predicted);
    items_sent++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (byte_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_field_select(logic [4:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    field_sel = value;
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(8'h20, 8'h7E));
    end while (c == nsc_pkg::CHAR_STAR);
    return c;
  endfunction

  function automatic void make_sentence();
    logic [47:0] tag;
    logic [7:0] sum;
    string digits;
    string non_hex;
    int nfields;
    int flen;
    int target;
    int cut;
    bit heavy;
    sentence_bytes.delete();
    digits = ($urandom_range(0, 3) == 0) ? "0123456789abcdef" : "0123456789ABCDEF";
    non_hex = "GZz!.g h";
    case ($urandom_range(0, 4))
      0: tag = GGA_TAG;
      1: tag = VTG_TAG;
      2: tag = "$GPGGA";
      3: begin
        tag = ($urandom_range(0, 1) == 0) ? GGA_TAG : VTG_TAG;
        tag[47 - 8 * $urandom_range(0, 5) -: 8] = 8'($urandom_range("A", "Z"));
      end
      default: begin
        tag = {40'd0, nsc_pkg::CHAR_DOLLAR};
        repeat (5) tag = {tag[39:0], 8'($urandom_range("A", "Z"))};
      end
    endcase
    for (int i = 0; i < 6; i++) sentence_bytes.push_back(tag[47 - 8 * i -: 8]);
    heavy = ($urandom_range(0, 5) == 0);
    nfields = heavy ? $urandom_range(30, 40) : $urandom_range(0, 8);
    for (int f = 0; f < nfields; f++) begin
      sentence_bytes.push_back(nsc_pkg::CHAR_COMMA);
      flen = heavy ? $urandom_range(0, 1) : $urandom_range(0, 6);
      repeat (flen) sentence_bytes.push_back(body_char());
    end
    if ($urandom_range(0, 24) == 0) begin
      target = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 20);
      while (sentence_bytes.size() < target) sentence_bytes.push_back(8'($urandom_range("0", "9")));
    end
    sum = 8'h00;
    foreach (sentence_bytes[i]) begin
      if (sentence_bytes[i] != 8'h00 && sentence_bytes[i] != nsc_pkg::CHAR_DOLLAR)
        sum ^= sentence_bytes[i];
    end
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        sum ^= 8'($urandom_range(1, 255));
        sentence_bytes.push_back(nsc_pkg::CHAR_STAR);
        sentence_bytes.push_back(digits[sum[7:4]]);
        sentence_bytes.push_back(digits[sum[3:0]]);
      end
      2: begin
        sentence_bytes.push_back(nsc_pkg::CHAR_STAR);
        if ($urandom_range(0, 1) == 0) begin
          sentence_bytes.push_back(digits[sum[7:4]]);
          sentence_bytes.push_back(non_hex[$urandom_range(0, 7)]);
        end else begin
          sentence_bytes.push_back(non_hex[$urandom_range(0, 7)]);
          sentence_bytes.push_back(digits[sum[3:0]]);
        end
      end
      3: begin
        sentence_bytes.push_back(nsc_pkg::CHAR_STAR);
        sentence_bytes.push_back(digits[sum[7:4]]);
      end
      default: begin
        sentence_bytes.push_back(nsc_pkg::CHAR_STAR);
        sentence_bytes.push_back(digits[sum[7:4]]);
        sentence_bytes.push_back(digits[sum[3:0]]);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) sentence_bytes.push_back(8'($urandom_range(1, 255)));
        end
      end
    endcase
    if ($urandom_range(0, 9) == 0) sentence_bytes.push_back(8'h00);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, sentence_bytes.size());
      while (sentence_bytes.size() > cut) void'(sentence_bytes.pop_back());
    end
  endfunction

  initial begin
    logic [4:0] selects [NUM_PHASES];
    int last;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 5'd0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_item(SCRIPT_BYTES[i].ch, SCRIPT_BYTES[i].eol, SCRIPT_BYTES[i].typed,
                SCRIPT_BYTES[i].res);
    end
    drain_results();

    selects[0] = 5'd1;
    selects[1] = 5'd31;
    selects[2] = 5'd0;
    selects[3] = 5'($urandom_range(3, 8));
    selects[4] = nsc_pkg::FIELD_SELECT_RESET;
    selects[5] = 5'($urandom_range(1, 31));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_field_select(selects[p]);
      if (p == 1) long_hold = 1'b1;
      if (p == NUM_PHASES - 1) calm = 1'b1;
      last = items_sent + PHASE_ITEMS;
      while (items_sent < last) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 12)) begin
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, '0);
          end
        end else begin
          make_sentence();
          foreach (sentence_bytes[i]) begin
            send_item(sentence_bytes[i], i == sentence_bytes.size() - 1, 1'b0, '0);
          end
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
